[hdl/telemetry_frame_crc16_encoder_defines.svh]
// Assertion macros for the telemetry frame encoder.
// Included by the modules that carry concurrent assertions; depends on nothing.
`ifndef TELEMETRY_FRAME_CRC16_ENCODER_DEFINES_SVH
`define TELEMETRY_FRAME_CRC16_ENCODER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TFCE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define TFCE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/tfce_pkg.sv]
// Package for the telemetry frame encoder: sequencer phases, frame marker bytes,
// register indexes and the byte-wide CRC-16 fold. Depends on nothing.
package tfce_pkg;

	localparam logic [7:0] MARK_FIRST  = 8'h21;	// '!'
	localparam logic [7:0] MARK_SECOND = 8'h24;	// '$'

	localparam logic [15:0] POLY_RESET = 16'h1021;
	localparam logic [15:0] INIT_RESET = 16'hFFFF;
	localparam logic [7:0]  DEV_RESET  = 8'h01;

	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] REG_POLYNOMIAL = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_INITIAL    = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_DEVICE     = 2'd2;

	// Which byte of a frame the sequencer puts out next
	typedef enum logic [2:0] {
		PH_MARK1,
		PH_MARK2,
		PH_LEN,
		PH_DEV,
		PH_KIND,
		PH_DATA,
		PH_CRC_LO,
		PH_CRC_HI
	} phase_t;

	// Shift one byte into an MSB-first CRC-16, eight bit steps
	function automatic logic [15:0] crc_fold(input logic [15:0] crc,
		input logic [15:0] poly, input logic [7:0] b);
		logic [15:0] r;
		r = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (r[15]) begin
				r = {r[14:0], 1'b0} ^ poly;
			end else begin
				r = {r[14:0], 1'b0};
			end
		end
		return r;
	endfunction

endpackage

[hdl/telemetry_frame_crc16_encoder.sv]
// Telemetry frame encoder: header / payload items in, frame bytes with CRC-16 out.
// Depends on tfce_pkg and telemetry_frame_crc16_encoder_defines.svh.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-----------------------------------------------
//   input    | in_valid / in_stall        | opcode, payload_length, message_kind, data_byte
//   output   | out_valid / out_stall      | out_byte, run_end, frame_end
//   config   | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// One frame byte leaves the output register per cycle unless out_stall holds it. A
// payload byte puts out 1 byte (3 when it is the last, with the trailer), a header 5
// (7 for a zero-length frame); a payload byte with no open frame puts out none. The CRC
// is folded one byte per cycle, stalls aside, as each header or payload byte is loaded
// into the output register; the next item is taken in the cycle its predecessor ends.
// Reset clears control state and loads the register defaults; a stall on the output
// holds the output register and, once the item register is busy, the input side.
`include "telemetry_frame_crc16_encoder_defines.svh"

module telemetry_frame_crc16_encoder
	import tfce_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,

	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   opcode,
	input  logic [7:0]             payload_length,
	input  logic [7:0]             message_kind,
	input  logic [7:0]             data_byte,

	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [7:0]             out_byte,
	output logic                   run_end,
	output logic                   frame_end,

	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [15:0]            cfg_data
);

	// configuration registers
	logic [15:0] poly_q;
	logic [15:0] init_q;
	logic [7:0]  dev_q;

	// frame state
	logic [15:0] crc_q;
	logic [7:0]  remaining_q;
	logic        open_q;

	// item register
	logic        slot_valid_s1;
	phase_t      phase_s1;
	logic [7:0]  len_s1;
	logic [7:0]  kind_s1;
	logic [7:0]  data_s1;

	// result register
	logic        out_valid_s2;
	logic [7:0]  out_byte_s2;
	logic        run_end_s2;
	logic        frame_end_s2;

	phase_t      phase_next;
	logic [7:0]  rem_dec;
	logic        out_free;
	logic        drop;
	logic        step;
	logic        emit;
	logic        in_accept;
	logic        last;
	logic        folds;
	logic [7:0]  cur_byte;
	logic [15:0] crc_base;
	logic [15:0] crc_folded;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q <= POLY_RESET;
			init_q <= INIT_RESET;
			dev_q  <= DEV_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_POLYNOMIAL: poly_q <= cfg_data;
				REG_INITIAL:    init_q <= cfg_data;
				REG_DEVICE:     dev_q  <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	assign rem_dec   = remaining_q - 8'd1;
	assign out_free  = !out_valid_s2 || !out_stall;
	assign drop      = (phase_s1 == PH_DATA) && !open_q;
	assign step      = slot_valid_s1 && (drop || out_free);
	assign emit      = slot_valid_s1 && out_free && !drop;
	assign in_stall  = slot_valid_s1 && !(step && last);
	assign in_accept = in_valid && !in_stall;

	// next phase of the sequencer
	always_comb begin
		unique case (phase_s1)
			PH_MARK1:  phase_next = PH_MARK2;
			PH_MARK2:  phase_next = PH_LEN;
			PH_LEN:    phase_next = PH_DEV;
			PH_DEV:    phase_next = PH_KIND;
			PH_KIND:   phase_next = (len_s1 == 8'd0) ? PH_CRC_LO : PH_MARK1;
			PH_DATA:   phase_next = (rem_dec == 8'd0) ? PH_CRC_LO : PH_MARK1;
			PH_CRC_LO: phase_next = PH_CRC_HI;
			PH_CRC_HI: phase_next = PH_MARK1;
			default:   phase_next = PH_MARK1;
		endcase
	end

	// byte, item end and CRC input for the current phase
	always_comb begin
		cur_byte = 8'h00;
		last     = 1'b0;
		folds    = 1'b1;
		crc_base = crc_q;
		unique case (phase_s1)
			PH_MARK1: begin
				cur_byte = MARK_FIRST;
				crc_base = init_q;
			end
			PH_MARK2:  cur_byte = MARK_SECOND;
			PH_LEN:    cur_byte = len_s1;
			PH_DEV:    cur_byte = dev_q;
			PH_KIND: begin
				cur_byte = kind_s1;
				last     = (len_s1 != 8'd0);
			end
			PH_DATA: begin
				cur_byte = data_s1;
				last     = !open_q || (rem_dec != 8'd0);
			end
			PH_CRC_LO: begin
				cur_byte = crc_q[7:0];
				folds    = 1'b0;
			end
			PH_CRC_HI: begin
				cur_byte = crc_q[15:8];
				last     = 1'b1;
				folds    = 1'b0;
			end
			default: begin
			end
		endcase
	end

	assign crc_folded = crc_fold(crc_base, poly_q, cur_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_s1 <= 1'b0;
			phase_s1      <= PH_MARK1;
		end else if (in_accept) begin
			slot_valid_s1 <= 1'b1;
			phase_s1      <= opcode ? PH_DATA : PH_MARK1;
		end else if (step) begin
			slot_valid_s1 <= !last;
			phase_s1      <= phase_next;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			len_s1  <= payload_length;
			kind_s1 <= message_kind;
			data_s1 <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q       <= '0;
			remaining_q <= '0;
			open_q      <= 1'b0;
		end else if (emit) begin
			if (folds) begin
				crc_q <= crc_folded;
			end
			if (phase_s1 == PH_KIND && len_s1 != 8'd0) begin
				open_q      <= 1'b1;
				remaining_q <= len_s1;
			end else if (phase_s1 == PH_DATA) begin
				remaining_q <= rem_dec;
			end else if (phase_s1 == PH_CRC_HI) begin
				open_q      <= 1'b0;
				remaining_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (emit) begin
			out_valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_s2  <= cur_byte;
			run_end_s2   <= last;
			frame_end_s2 <= (phase_s1 == PH_CRC_HI);
		end
	end

	assign out_valid = out_valid_s2;
	assign out_byte  = out_byte_s2;
	assign run_end   = run_end_s2;
	assign frame_end = frame_end_s2;

	`TFCE_ASSERT_NOW(a_frame_end_closes_item, clk, arst_n,
		out_valid_s2 && frame_end_s2, run_end_s2, "frame end without item end")
	// the count reaches zero only while the trailer is going out
	`TFCE_ASSERT_NOW(a_open_has_bytes, clk, arst_n,
		open_q, remaining_q != 8'd0 || phase_s1 == PH_CRC_LO || phase_s1 == PH_CRC_HI,
		"open frame with no bytes remaining")
	`TFCE_ASSERT_NEXT(a_crc_lo_then_hi, clk, arst_n,
		emit && phase_s1 == PH_CRC_LO, slot_valid_s1 && phase_s1 == PH_CRC_HI,
		"trailer low byte not followed by high byte")
	`TFCE_ASSERT_NEXT(a_emit_fills_output, clk, arst_n,
		emit, out_valid_s2, "emitted byte missing from output register")

endmodule

[test/tb.sv]
// Self-checking bench for telemetry_frame_crc16_encoder: frame headers and payload items in,
// framed bytes with a CRC-16 trailer out, checked against an in-bench frame predictor.
// Depends on tfce_pkg and the encoder RTL only.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tfce_pkg::*;

	localparam logic OP_HEADER  = 1'b0;
	localparam logic OP_PAYLOAD = 1'b1;
	localparam int   SETTLE     = 12;
	localparam int   HOLD_LEN   = 150;
	localparam int   CYCLE_CAP  = 200000;

	typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY, RX_EVERY_THIRD} rx_mode_t;

	typedef struct {
		logic [7:0] value;
		logic       run_end;
		logic       frame_end;
	} frame_byte_t;

	class frame_scoreboard;
		logic [15:0] poly, seed, crc;
		logic [7:0]  dev_id, bytes_left;
		logic        in_frame;
		int          errors;
		frame_byte_t due[$];

		function new();
			poly = POLY_RESET;
			seed = INIT_RESET;
			dev_id = DEV_RESET;
			crc = '0;
			bytes_left = '0;
			in_frame = 1'b0;
			errors = 0;
		endfunction

		function void note_config(logic [CFG_INDEX_W-1:0] index, logic [15:0] value);
			case (index)
			REG_POLYNOMIAL: poly = value;
			REG_INITIAL: seed = value;
			REG_DEVICE: dev_id = value[7:0];
			default: ;
			endcase
		endfunction

		function void emit(logic [7:0] b, logic last_crc);
			due.push_back('{value: b, run_end: 1'b0, frame_end: last_crc});
		endfunction

		// Fold the byte bit by bit, MSB first, then queue it for output
		function void emit_data(logic [7:0] b);
			logic fb;
			for (int i = 7; i >= 0; i--) begin
				fb = crc[15] ^ b[i];
				crc = {crc[14:0], 1'b0};
				if (fb) begin
					crc = crc ^ poly;
				end
			end
			emit(b, 1'b0);
		endfunction

		function void emit_trailer();
			emit(crc[7:0], 1'b0);
			emit(crc[15:8], 1'b1);
			in_frame = 1'b0;
			bytes_left = '0;
		endfunction

		function void note_item(logic op, logic [7:0] len, logic [7:0] kind, logic [7:0] data);
			int first;
			first = due.size();
			if (op == OP_HEADER) begin
				// a new header drops any open frame without a trailer
				crc = seed;
				emit_data(MARK_FIRST);
				emit_data(MARK_SECOND);
				emit_data(len);
				emit_data(dev_id);
				emit_data(kind);
				if (len == 8'd0) begin
					emit_trailer();
				end else begin
					in_frame = 1'b1;
					bytes_left = len;
				end
			end else if (in_frame) begin
				emit_data(data);
				bytes_left = bytes_left - 8'd1;
				if (bytes_left == 8'd0) begin
					emit_trailer();
				end
			end
			if (due.size() > first) begin
				due[due.size()-1].run_end = 1'b1;
			end
		endfunction

		task report(string msg);
			errors++;
			// keep the log short when everything goes wrong
			if (errors <= 100) begin
				$display("MISMATCH at %0t: %s", $time, msg);
			end
		endtask

		task check_result(logic [7:0] b, logic re, logic fe);
			frame_byte_t want;
			if (due.size() == 0) begin
				report($sformatf("byte %02h with nothing expected", b));
			end else begin
				want = due.pop_front();
				if (b !== want.value) begin
					report($sformatf("out_byte %02h, expected %02h", b, want.value));
				end
				if (re !== want.run_end) begin
					report($sformatf("run_end %b, expected %b", re, want.run_end));
				end
				if (fe !== want.frame_end) begin
					report($sformatf("frame_end %b, expected %b", fe, want.frame_end));
				end
			end
		endtask
	endclass

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic                   opcode = 1'b0;
	logic [7:0]             payload_length = '0;
	logic [7:0]             message_kind = '0;
	logic [7:0]             data_byte = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [7:0]             out_byte;
	logic                   run_end;
	logic                   frame_end;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [15:0]            cfg_data = '0;

	frame_scoreboard sb;
	logic     steady = 1'b0;
	logic     hold_req = 1'b0;
	int       burst_left = 0;
	int       hold_left = 0;
	int       mode_left = 0;
	rx_mode_t rx_mode = RX_FREE;

	telemetry_frame_crc16_encoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.payload_length(payload_length),
		.message_kind(message_kind),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.run_end(run_end),
		.frame_end(frame_end),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_CAP) @(posedge clk);
		$display("Test completed with failures");
		$finish;
	end

	// Receiver: a long hold-off on request, otherwise a stall pattern that changes now and then
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_LEN;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(16, 96);
			end
			mode_left--;
			case (rx_mode)
			RX_FREE: out_stall <= 1'b0;
			RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= (mode_left % 3 == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_result(out_byte, run_end, frame_end);
		end
	end

	// Offer one item, wait for it to be taken, then either keep the burst going or idle a while
	task push_item(logic op, logic [7:0] len, logic [7:0] kind, logic [7:0] data);
		in_valid <= 1'b1;
		opcode <= op;
		payload_length <= len;
		message_kind <= kind;
		data_byte <= data;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_item(op, len, kind, data);
		if (steady || burst_left > 0) begin
			if (burst_left > 0) begin
				burst_left--;
			end
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
		end
	endtask

	// Hold the input until every expected byte is out, plus slack for a dropped item
	task drain();
		in_valid <= 1'b0;
		while (sb.due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task write_reg(logic [CFG_INDEX_W-1:0] index, logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.note_config(index, value);
	endtask

	task set_config(logic [15:0] poly, logic [15:0] seed, logic [7:0] dev);
		drain();
		write_reg(REG_POLYNOMIAL, poly);
		write_reg(REG_INITIAL, seed);
		write_reg(REG_DEVICE, {8'($urandom), dev});
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly complete frames with random content; some abandoned, some stray payload bytes
	task random_frames(int items);
		int         sent;
		int         body;
		int unsigned pick;
		logic [7:0] len;
		sent = 0;
		while (sent < items) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				len = 8'($urandom_range(0, 6));
			end else if (pick < 92) begin
				len = 8'($urandom_range(7, 24));
			end else begin
				len = 8'($urandom_range(25, 255));
			end
			body = int'(len);
			if (len != 8'd0 && (len > 8'd24 || $urandom_range(0, 9) == 0)) begin
				body = int'($urandom_range(0, (len > 8'd8) ? 8 : int'(len) - 1));
			end
			push_item(OP_HEADER, len, 8'($urandom), 8'($urandom));
			sent++;
			repeat (body) begin
				push_item(OP_PAYLOAD, 8'($urandom), 8'($urandom), 8'($urandom));
				sent++;
			end
			// frame closed: a stray byte here must be dropped
			if (body == int'(len) && $urandom_range(0, 7) == 0) begin
				push_item(OP_PAYLOAD, 8'($urandom), 8'($urandom), 8'($urandom));
				sent++;
			end
			if ($urandom_range(0, 19) == 0) begin
				drain();
			end
		end
	endtask

	initial begin
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// payload with no frame open: dropped
		push_item(OP_PAYLOAD, 8'hFF, 8'hFF, 8'hFF);
		push_item(OP_PAYLOAD, 8'h00, 8'h00, 8'h00);
		// zero-length frames: header and trailer from one item
		push_item(OP_HEADER, 8'd0, 8'h00, 8'hFF);
		push_item(OP_HEADER, 8'd0, 8'hFF, 8'h00);
		push_item(OP_HEADER, 8'd1, 8'hA5, 8'h5A);
		push_item(OP_PAYLOAD, 8'h5A, 8'hA5, 8'h00);
		push_item(OP_HEADER, 8'd3, 8'h3C, 8'h00);
		push_item(OP_PAYLOAD, 8'h00, 8'h00, 8'hFF);
		push_item(OP_PAYLOAD, 8'hFF, 8'hFF, 8'h80);
		push_item(OP_PAYLOAD, 8'h00, 8'h00, 8'h01);
		// longest frame, abandoned by the next header
		push_item(OP_HEADER, 8'd255, 8'h80, 8'h7F);
		push_item(OP_PAYLOAD, 8'h00, 8'h00, 8'h12);
		push_item(OP_PAYLOAD, 8'h00, 8'h00, 8'h34);
		push_item(OP_HEADER, 8'd2, 8'h01, 8'h00);
		push_item(OP_PAYLOAD, 8'h00, 8'h00, 8'hC3);
		push_item(OP_PAYLOAD, 8'h00, 8'h00, 8'h3C);
		push_item(OP_PAYLOAD, 8'h00, 8'h00, 8'h77);
		random_frames(18);

		set_config(16'h0000, 16'h0000, 8'h00);
		random_frames(16);

		// receiver holds off while the sender keeps offering items back to back
		set_config(16'hFFFF, 16'hFFFF, 8'hFF);
		hold_req = 1'b1;
		steady = 1'b1;
		random_frames(8);
		steady = 1'b0;
		random_frames(8);

		set_config(16'h8005, 16'h0000, 8'($urandom));
		random_frames(16);

		set_config(16'($urandom), 16'($urandom), 8'($urandom));
		random_frames(16);

		set_config(16'h1021, 16'h1D0F, 8'h5A);
		random_frames(16);

		drain();
		if (sb.errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule

[files.f]
+incdir+hdl
hdl/tfce_pkg.sv
hdl/telemetry_frame_crc16_encoder.sv
test/tb.sv
